/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion helpers used by axis_vector_rotation_unit
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define AVR_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define AVR_NEVER(lbl, clk_i, rst_ni, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* rtl/avr_pkg.sv */
// ---------------------------------------------------------------------------
// avr_pkg
// Shared constants, types and the arctangent table of the axis rotation unit.
// ---------------------------------------------------------------------------
package avr_pkg;

  // default build parameters
  localparam int CORDIC_STEPS_DEF = 20;
  localparam int COORD_BITS_DEF   = 32;

  // axis selector codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // angle path widths: input in Q4.16, internal path in Q.24 radians
  localparam int ANG_IN_W = 20;
  localparam int ANG_W    = 28;

  // cordic working width (Q.30 with headroom) and sine/cosine width
  localparam int CS_W   = 33;
  localparam int TRIG_W = 32;

  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 28'sd105414357;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;

  localparam logic signed [CS_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [CS_W-1:0] ONE_Q30  = 33'sd1073741824;

  // cosine, sine and negated sine in Q.30
  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] neg_s;
  } trig_t;

  // atan(2^-i) in Q.24, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q24(input logic [4:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      5'd0:    val = 28'sd13176795;
      5'd1:    val = 28'sd7778716;
      5'd2:    val = 28'sd4110060;
      5'd3:    val = 28'sd2086331;
      5'd4:    val = 28'sd1047214;
      5'd5:    val = 28'sd524117;
      5'd6:    val = 28'sd262123;
      5'd7:    val = 28'sd131069;
      5'd8:    val = 28'sd65536;
      5'd9:    val = 28'sd32768;
      5'd10:   val = 28'sd16384;
      5'd11:   val = 28'sd8192;
      5'd12:   val = 28'sd4096;
      5'd13:   val = 28'sd2048;
      5'd14:   val = 28'sd1024;
      5'd15:   val = 28'sd512;
      5'd16:   val = 28'sd256;
      5'd17:   val = 28'sd128;
      5'd18:   val = 28'sd64;
      5'd19:   val = 28'sd32;
      5'd20:   val = 28'sd16;
      5'd21:   val = 28'sd8;
      5'd22:   val = 28'sd4;
      5'd23:   val = 28'sd2;
      5'd24:   val = 28'sd1;
      default: val = 28'sd0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/avr_cordic.sv */
// ---------------------------------------------------------------------------
// avr_cordic
// Pipelined sine/cosine: angle reduction, quadrant fold, one cordic step per
// stage, then sign restore and clamp into the output register.
// ---------------------------------------------------------------------------
module avr_cordic
  import avr_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [ANG_IN_W-1:0] turn_angle,
  output trig_t                      trig
);

  logic signed [ANG_W-1:0] ang_ext;
  logic signed [ANG_W-1:0] ang_red;
  logic signed [ANG_W-1:0] za_r;
  logic signed [ANG_W-1:0] zf_nxt;
  logic                    flip_nxt;

  logic signed [CS_W-1:0]  x_r    [0:CORDIC_STEPS];
  logic signed [CS_W-1:0]  y_r    [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] z_r    [0:CORDIC_STEPS];
  logic                    flip_r [0:CORDIC_STEPS];

  logic signed [CS_W-1:0]  xf;
  logic signed [CS_W-1:0]  yf;
  logic signed [CS_W-1:0]  xc;
  logic signed [CS_W-1:0]  yc;
  logic signed [CS_W-1:0]  yn;
  trig_t                   trig_r;

  // Q4.16 to Q.24, then one wrap by 2*pi
  always_comb begin
    ang_ext = $signed({turn_angle, 8'd0});
    if (ang_ext > ANG_PI) begin
      ang_red = ang_ext - ANG_TWO_PI;
    end else if (ang_ext < -ANG_PI) begin
      ang_red = ang_ext + ANG_TWO_PI;
    end else begin
      ang_red = ang_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za_r <= ang_red;
    end
  end

  // fold into the right half plane, remember to flip signs
  always_comb begin
    if (za_r > ANG_HALF_PI) begin
      zf_nxt   = za_r - ANG_PI;
      flip_nxt = 1'b1;
    end else if (za_r < -ANG_HALF_PI) begin
      zf_nxt   = za_r + ANG_PI;
      flip_nxt = 1'b1;
    end else begin
      zf_nxt   = za_r;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= zf_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  // one rotation step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CS_W-1:0]  dx;
    logic signed [CS_W-1:0]  dy;
    logic signed [ANG_W-1:0] at;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = atan_q24(5'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ANG_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  // sign restore and clamp to [-1, 1]
  always_comb begin
    xf = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    yf = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    if (xf > ONE_Q30) begin
      xc = ONE_Q30;
    end else if (xf < -ONE_Q30) begin
      xc = -ONE_Q30;
    end else begin
      xc = xf;
    end
    if (yf > ONE_Q30) begin
      yc = ONE_Q30;
    end else if (yf < -ONE_Q30) begin
      yc = -ONE_Q30;
    end else begin
      yc = yf;
    end
    yn = -yc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_r.c     <= TRIG_W'(xc);
      trig_r.s     <= TRIG_W'(yc);
      trig_r.neg_s <= TRIG_W'(yn);
    end
  end

  assign trig = trig_r;

endmodule

/* rtl/avr_lin.sv */
// ---------------------------------------------------------------------------
// avr_lin
// Exact a*t1 + b*t2 in Q.30, rounded to nearest (ties up) and saturated.
// Coordinates split at bit 16 so each multiplier stays at 17x32.
// Three register stages; result and clip flag follow the last one.
// ---------------------------------------------------------------------------
module avr_lin
  import avr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] a,
  input  logic signed [COORD_BITS-1:0] b,
  input  logic signed [TRIG_W-1:0]     t1,
  input  logic signed [TRIG_W-1:0]     t2,
  output logic signed [COORD_BITS-1:0] q,
  output logic                         clip
);

  localparam int AH_W = COORD_BITS - 15;
  localparam int PH_W = AH_W + TRIG_W;
  localparam int PL_W = 17 + TRIG_W;
  localparam int F_W  = COORD_BITS + 35;
  localparam int Q_W  = F_W - 30;

  logic signed [AH_W-1:0] ah;
  logic signed [AH_W-1:0] bh;
  logic signed [16:0]     al;
  logic signed [16:0]     bl;

  logic signed [PH_W-1:0]   pa_hi_r;
  logic signed [PH_W-1:0]   pb_hi_r;
  logic signed [PL_W-1:0]   pa_lo_r;
  logic signed [PL_W-1:0]   pb_lo_r;
  logic signed [PH_W:0]     hi_r;
  logic signed [PL_W:0]     lo_r;
  logic signed [F_W-1:0]    f_r;
  logic signed [Q_W-1:0]    q_full;
  logic                     ovf;

  // split coordinates: floor high part and unsigned low 16 bits
  assign ah = AH_W'($signed({a[COORD_BITS-1], a}) >>> 16);
  assign bh = AH_W'($signed({b[COORD_BITS-1], b}) >>> 16);
  assign al = $signed({1'b0, a[15:0]});
  assign bl = $signed({1'b0, b[15:0]});

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pa_hi_r <= ah * t1;
      pb_hi_r <= bh * t2;
      pa_lo_r <= al * t1;
      pb_lo_r <= bl * t2;
    end
  end

  // high and low sums
  always_ff @(posedge clk) begin
    if (en) begin
      hi_r <= (PH_W+1)'(pa_hi_r) + (PH_W+1)'(pb_hi_r);
      lo_r <= (PL_W+1)'(pa_lo_r) + (PL_W+1)'(pb_lo_r);
    end
  end

  // recombine with rounding offset of one half
  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= (F_W'(hi_r) <<< 16) + F_W'(lo_r) + (F_W'(1) <<< 29);
    end
  end

  // drop fraction, saturate to the coordinate range
  always_comb begin
    q_full = Q_W'(f_r >>> 30);
    ovf    = (q_full[Q_W-1:COORD_BITS-1] != '0) && (q_full[Q_W-1:COORD_BITS-1] != '1);
    if (ovf) begin
      q = q_full[Q_W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      q = q_full[COORD_BITS-1:0];
    end
    clip = ovf;
  end

endmodule

/* rtl/axis_vector_rotation_unit.sv */
// ---------------------------------------------------------------------------
// axis_vector_rotation_unit
// Rotates a Q16.16 vector about the x, y or z axis by a Q4.16 angle.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat: in_cmd selects the axis (x, y, z; code three passes the
//   vector through), in_x/in_y/in_z are signed Q16.16, in_turn_angle is
//   signed Q4.16 radians. Output beat: rotated out_x/out_y/out_z, saturated
//   to the coordinate range, and out_clipped when any component saturated.
//   Both channels are valid/ready.
//   From input beat to output valid a beat passes two angle reduction
//   stages, one stage per cordic step, one clamp stage, three product/sum
//   stages and the output register. Throughput is one beat per clock
//   while the receiver does not stall.
//   Reset clears only the valid bits; the block keeps no other state.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module axis_vector_rotation_unit
  import avr_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_cmd,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  input  logic signed [ANG_IN_W-1:0]   in_turn_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic                         out_clipped
);

  // stage where sine/cosine become available, and total side-band depth
  localparam int TRIG_AT = CORDIC_STEPS + 2;
  localparam int MD      = CORDIC_STEPS + 6;

  localparam logic signed [COORD_BITS-1:0] SAT_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] SAT_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                         pipe_en;
  logic [MD-1:0]                vld_r;
  logic [1:0]                   cmd_r [0:MD-1];
  logic signed [COORD_BITS-1:0] vx_r  [0:MD-1];
  logic signed [COORD_BITS-1:0] vy_r  [0:MD-1];
  logic signed [COORD_BITS-1:0] vz_r  [0:MD-1];

  trig_t                        trig;
  logic signed [COORD_BITS-1:0] op_a;
  logic signed [COORD_BITS-1:0] op_b;
  logic signed [COORD_BITS-1:0] qa;
  logic signed [COORD_BITS-1:0] qb;
  logic                         clip_a;
  logic                         clip_b;

  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] ox_r;
  logic signed [COORD_BITS-1:0] oy_r;
  logic signed [COORD_BITS-1:0] oz_r;
  logic                         oclip_r;
  logic signed [COORD_BITS-1:0] ox_nxt;
  logic signed [COORD_BITS-1:0] oy_nxt;
  logic signed [COORD_BITS-1:0] oz_nxt;
  logic                         oclip_nxt;
  logic                         at_bound;

  // whole pipeline moves unless a result sits unaccepted
  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[MD-2:0], in_valid && in_ready};
    end
  end

  // axis code and vector travel beside the arithmetic
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cmd_r[0] <= in_cmd;
      vx_r[0]  <= in_x;
      vy_r[0]  <= in_y;
      vz_r[0]  <= in_z;
      for (int k = 1; k < MD; k++) begin
        cmd_r[k] <= cmd_r[k-1];
        vx_r[k]  <= vx_r[k-1];
        vy_r[k]  <= vy_r[k-1];
        vz_r[k]  <= vz_r[k-1];
      end
    end
  end

  avr_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .en        (pipe_en),
    .turn_angle(in_turn_angle),
    .trig      (trig)
  );

  // pick the two components in the rotation plane
  always_comb begin
    case (cmd_r[TRIG_AT])
      AXIS_X: begin
        op_a = vy_r[TRIG_AT];
        op_b = vz_r[TRIG_AT];
      end
      AXIS_Y: begin
        op_a = vz_r[TRIG_AT];
        op_b = vx_r[TRIG_AT];
      end
      default: begin
        op_a = vx_r[TRIG_AT];
        op_b = vy_r[TRIG_AT];
      end
    endcase
  end

  // a' = c*a - s*b
  avr_lin #(
    .COORD_BITS(COORD_BITS)
  ) u_lin_a (
    .clk (clk),
    .en  (pipe_en),
    .a   (op_a),
    .b   (op_b),
    .t1  (trig.c),
    .t2  (trig.neg_s),
    .q   (qa),
    .clip(clip_a)
  );

  // b' = s*a + c*b
  avr_lin #(
    .COORD_BITS(COORD_BITS)
  ) u_lin_b (
    .clk (clk),
    .en  (pipe_en),
    .a   (op_a),
    .b   (op_b),
    .t1  (trig.s),
    .t2  (trig.c),
    .q   (qb),
    .clip(clip_b)
  );

  // put rotated components back in place
  always_comb begin
    ox_nxt    = vx_r[MD-1];
    oy_nxt    = vy_r[MD-1];
    oz_nxt    = vz_r[MD-1];
    oclip_nxt = clip_a || clip_b;
    case (cmd_r[MD-1])
      AXIS_X: begin
        oy_nxt = qa;
        oz_nxt = qb;
      end
      AXIS_Y: begin
        oz_nxt = qa;
        ox_nxt = qb;
      end
      AXIS_Z: begin
        ox_nxt = qa;
        oy_nxt = qb;
      end
      default: begin
        oclip_nxt = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= vld_r[MD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ox_r    <= ox_nxt;
      oy_r    <= oy_nxt;
      oz_r    <= oz_nxt;
      oclip_r <= oclip_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x       = ox_r;
  assign out_y       = oy_r;
  assign out_z       = oz_r;
  assign out_clipped = oclip_r;

  // some output component sits on a saturation bound
  assign at_bound = (ox_r == SAT_HI) || (ox_r == SAT_LO) || (oy_r == SAT_HI) ||
                    (oy_r == SAT_LO) || (oz_r == SAT_HI) || (oz_r == SAT_LO);

  // checks
  `AVR_ASSERT(a_enter, clk, rst_n, (in_valid && in_ready) |=> vld_r[0], "accepted beat not in first stage")
  `AVR_ASSERT(a_hold, clk, rst_n, !pipe_en |=> $stable(vld_r), "pipeline moved during stall")
  `AVR_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_r) |-> $past(vld_r[MD-1]), "result without source")
  `AVR_NEVER(a_clip_bound, clk, rst_n, out_valid_r && oclip_r && !at_bound, "clip flag without bound")

endmodule

/* verif/axis_vector_rotation_unit_tb.sv */
// ---------------------------------------------------------------------------
// axis_vector_rotation_unit_tb
// Self-checking bench for the axis rotation unit. A short table of directed
// beats covers the pass-through code, zero vectors, every axis, the angle
// and coordinate extremes and saturation. About 1300 random beats follow.
// Every output beat is compared field by field with a bit-exact CORDIC
// predictor of the rotation. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module axis_vector_rotation_unit_tb;
  import avr_pkg::*;

  localparam int  RANDOM_BEATS = 1300;
  localparam int  QUIET_LIMIT  = 3000;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  TRIG_STEPS   = 20;
  localparam int  Q16_ONE      = 65536;

  // angle constants in Q.24, sine/cosine constants in Q.30
  localparam longint TWO_PI_Q24  = 105414357;
  localparam longint PI_Q24      = 52707179;
  localparam longint HALF_PI_Q24 = 26353589;
  localparam longint CORDIC_K    = 652032874;
  localparam longint UNIT_Q30    = 1073741824;

  // angles in Q4.16
  localparam logic signed [19:0] ANG_ZERO    = 20'sd0;
  localparam logic signed [19:0] ANG_QUARTER = 20'sd51472;
  localparam logic signed [19:0] ANG_RIGHT   = 20'sd102944;
  localparam logic signed [19:0] ANG_HALF    = 20'sd205887;
  localparam logic signed [19:0] ANG_MAX     = 20'sh7FFFF;
  localparam logic signed [19:0] ANG_MIN     = 20'sh80000;

  localparam logic signed [31:0] C_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] C_MIN = 32'sh80000000;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [19:0] ang;
  } rot_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               clip;
  } rot_res_t;

  typedef struct {
    rot_req_t req;
    bit       known;
    rot_res_t res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = AXIS_NONE;
  logic signed [31:0] in_x = '0;
  logic signed [31:0] in_y = '0;
  logic signed [31:0] in_z = '0;
  logic signed [19:0] in_turn_angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               out_clipped;

  rot_res_t pending_rotations[$];
  dir_row_t dir_rows[$];
  int       mismatch_count = 0;
  bit       calm = 1'b0;

  always #1 clk = ~clk;

  axis_vector_rotation_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .in_turn_angle(in_turn_angle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_clipped  (out_clipped)
  );

  // round a two-term product sum from Q.30 and saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input longint a, input longint t1,
                                                   input longint b, input longint t2,
                                                   inout bit clip);
    longint acc;
    acc = (a * t1 + b * t2 + (64'sd1 <<< 29)) >>> 30;
    if (acc > 64'sd2147483647) begin
      clip = 1'b1;
      return C_MAX;
    end
    if (acc < -64'sd2147483648) begin
      clip = 1'b1;
      return C_MIN;
    end
    return acc[31:0];
  endfunction

  // expected output beat for one input beat
  function automatic rot_res_t rotated_vector(input rot_req_t r);
    longint   vec[3];
    longint   phase, cx, sy, dx, dy, na, nb;
    bit       flip, clip;
    int       i, ia, ib;
    rot_res_t res;
    vec[0] = r.x;
    vec[1] = r.y;
    vec[2] = r.z;
    clip = 1'b0;
    if (r.cmd != AXIS_NONE) begin
      // bring the angle into [-pi/2, pi/2], remembering a half-turn fold
      phase = longint'(r.ang) * 256;
      flip = 1'b0;
      if (phase > PI_Q24) phase -= TWO_PI_Q24;
      else if (phase < -PI_Q24) phase += TWO_PI_Q24;
      if (phase > HALF_PI_Q24) begin
        phase -= PI_Q24;
        flip = 1'b1;
      end else if (phase < -HALF_PI_Q24) begin
        phase += PI_Q24;
        flip = 1'b1;
      end
      // rotation-mode cordic in Q.30
      cx = CORDIC_K;
      sy = 0;
      for (i = 0; i < TRIG_STEPS; i++) begin
        dx = sy >>> i;
        dy = cx >>> i;
        if (phase >= 0) begin
          cx -= dx;
          sy += dy;
          phase -= longint'($atan(1.0 / (2.0 ** i)) * 16777216.0);
        end else begin
          cx += dx;
          sy -= dy;
          phase += longint'($atan(1.0 / (2.0 ** i)) * 16777216.0);
        end
      end
      if (flip) begin
        cx = -cx;
        sy = -sy;
      end
      if (cx > UNIT_Q30) cx = UNIT_Q30;
      if (cx < -UNIT_Q30) cx = -UNIT_Q30;
      if (sy > UNIT_Q30) sy = UNIT_Q30;
      if (sy < -UNIT_Q30) sy = -UNIT_Q30;
      // the two coordinates across the axis, in right-handed order
      ia = (int'(r.cmd) + 1) % 3;
      ib = (int'(r.cmd) + 2) % 3;
      na = round_sat(vec[ia], cx, vec[ib], -sy, clip);
      nb = round_sat(vec[ia], sy, vec[ib], cx, clip);
      vec[ia] = na;
      vec[ib] = nb;
    end
    res.x = vec[0][31:0];
    res.y = vec[1][31:0];
    res.z = vec[2][31:0];
    res.clip = clip;
    return res;
  endfunction

  // coordinate mix: extremes, full range and small values
  function automatic logic signed [31:0] random_coord();
    logic signed [20:0] near;
    near = 21'($urandom);
    case ($urandom_range(7))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3, 4: return $urandom;
      default: return near;
    endcase
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic signed [31:0] x,
                         input logic signed [31:0] y, input logic signed [31:0] z,
                         input logic signed [19:0] ang, input bit known,
                         input logic signed [31:0] ex, input logic signed [31:0] ey,
                         input logic signed [31:0] ez, input logic eclip);
    dir_row_t row;
    row.req = '{cmd, x, y, z, ang};
    row.known = known;
    row.res = '{ex, ey, ez, eclip};
    dir_rows.push_back(row);
  endtask

  // drive one input beat, hold it until taken, then record its expectation
  task automatic send_vector(input rot_req_t r, input bit known, input rot_res_t res);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 31) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= r.cmd;
    in_x          <= r.x;
    in_y          <= r.y;
    in_z          <= r.z;
    in_turn_angle <= r.ang;
    do @(posedge clk); while (!in_ready);
    pending_rotations.push_back(known ? res : rotated_vector(r));
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    rot_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rotations.size() == 0) begin
        $error("output beat with no expectation waiting");
        mismatch_count++;
      end else begin
        want = pending_rotations.pop_front();
        if (out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, out_x);
          mismatch_count++;
        end
        if (out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, out_y);
          mismatch_count++;
        end
        if (out_z !== want.z) begin
          $error("out_z: expected %0d, got %0d", want.z, out_z);
          mismatch_count++;
        end
        if (out_clipped !== want.clip) begin
          $error("out_clipped: expected %0d, got %0d", want.clip, out_clipped);
          mismatch_count++;
        end
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 31);
  end

  // watchdog on cycles with no beat on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    rot_req_t r;
    rot_res_t unused;
    int       sel, n;
    unused = '{'0, '0, '0, 1'b0};

    // pass-through code and zero vectors have results known up front
    add_row(AXIS_NONE, C_MAX, C_MIN, 32'sd12345, ANG_ZERO, 1, C_MAX, C_MIN, 32'sd12345, 0);
    add_row(AXIS_NONE, C_MIN, C_MAX, -32'sd1, ANG_MAX, 1, C_MIN, C_MAX, -32'sd1, 0);
    add_row(AXIS_NONE, '0, '0, '0, ANG_MIN, 1, '0, '0, '0, 0);
    add_row(AXIS_X, '0, '0, '0, ANG_RIGHT, 1, '0, '0, '0, 0);
    add_row(AXIS_Z, '0, '0, '0, ANG_MIN, 1, '0, '0, '0, 0);
    // zero angle on each axis
    add_row(AXIS_X, Q16_ONE, 2 * Q16_ONE, 3 * Q16_ONE, ANG_ZERO, 0, '0, '0, '0, 0);
    add_row(AXIS_Y, Q16_ONE, 2 * Q16_ONE, 3 * Q16_ONE, ANG_ZERO, 0, '0, '0, '0, 0);
    add_row(AXIS_Z, Q16_ONE, 2 * Q16_ONE, 3 * Q16_ONE, ANG_ZERO, 0, '0, '0, '0, 0);
    // right angle, half turn and angle extremes, folded in the reduction
    add_row(AXIS_X, Q16_ONE, -Q16_ONE, Q16_ONE, ANG_RIGHT, 0, '0, '0, '0, 0);
    add_row(AXIS_Y, Q16_ONE, -Q16_ONE, Q16_ONE, -ANG_RIGHT, 0, '0, '0, '0, 0);
    add_row(AXIS_Z, Q16_ONE, -Q16_ONE, Q16_ONE, ANG_HALF, 0, '0, '0, '0, 0);
    add_row(AXIS_X, 7 * Q16_ONE, -5 * Q16_ONE, 3, ANG_MAX, 0, '0, '0, '0, 0);
    add_row(AXIS_Y, 7 * Q16_ONE, -5 * Q16_ONE, 3, ANG_MIN, 0, '0, '0, '0, 0);
    add_row(AXIS_Z, 7 * Q16_ONE, -5 * Q16_ONE, 3, -ANG_HALF, 0, '0, '0, '0, 0);
    // coordinate extremes, driving saturation both ways
    add_row(AXIS_Z, C_MIN, C_MIN, '0, ANG_QUARTER, 0, '0, '0, '0, 0);
    add_row(AXIS_Z, C_MAX, C_MAX, '0, ANG_QUARTER, 0, '0, '0, '0, 0);
    add_row(AXIS_X, '0, C_MAX, C_MIN, -ANG_QUARTER, 0, '0, '0, '0, 0);
    add_row(AXIS_Y, C_MAX, 32'sd5, C_MIN, -ANG_HALF, 0, '0, '0, '0, 0);
    add_row(AXIS_Z, C_MIN, C_MAX, C_MAX, ANG_HALF, 0, '0, '0, '0, 0);
    // smallest angles and coordinates, next to extreme ones
    add_row(AXIS_X, -32'sd1, -32'sd1, -32'sd1, 20'sd1, 0, '0, '0, '0, 0);
    add_row(AXIS_Y, C_MIN, C_MIN, C_MIN, -20'sd1, 0, '0, '0, '0, 0);
    add_row(AXIS_Z, 32'sd1, 32'sd1, 32'sd1, ANG_MAX, 0, '0, '0, '0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) send_vector(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);

    // random beats, with one stretch where neither side idles
    for (n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= 500 && n < 800);
      sel = $urandom_range(9);
      r.cmd = (sel == 0) ? AXIS_NONE : (sel < 4) ? AXIS_X : (sel < 7) ? AXIS_Y : AXIS_Z;
      r.x = random_coord();
      r.y = random_coord();
      r.z = random_coord();
      r.ang = 20'($urandom);
      send_vector(r, 1'b0, unused);
    end
    calm = 1'b0;

    // drain the pipeline
    in_valid <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
